/* rtl/core/lhas_pkg.sv */
// Shared types, codes and sizes for the load history autoscaler.
package lhas_pkg;

    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CNT_W      = HIST_AW + 1;

    localparam int DIV_NUM_W  = 24;
    localparam int DIV_DEN_W  = 17;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_UP      = 2'd1,
        ACT_DOWN    = 2'd2,
        ACT_NO_WORK = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_MAX_WORKERS = 3'd0,
        CFG_MIN_WORKERS = 3'd1,
        CFG_UP_THRESH   = 3'd2,
        CFG_DOWN_THRESH = 3'd3,
        CFG_UP_NEEDED   = 3'd4,
        CFG_UP_WINDOW   = 3'd5,
        CFG_DOWN_WINDOW = 3'd6,
        CFG_DOWN_DELAY  = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_DIV,
        ST_WALK,
        ST_DECIDE,
        ST_EST_START,
        ST_EST_DIV,
        ST_RS_READ,
        ST_RS_START,
        ST_RS_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

/* rtl/core/lhas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lhas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lhas_div.sv */
// Restoring divider, one quotient bit per cycle.
module lhas_div
    import lhas_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    assign rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

/* rtl/core/load_history_autoscaler_top.sv */
// Top level of the load history autoscaler: control sequencer, history RAM, divider.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------------
//  s_*     | in  | s_tvalid/tready  | tick request: total_load, worker_count
//  m_*     | out | m_tvalid/tready  | decision: action, average_load, estimated_load,
//          |     |                  |           over_count, under_count
//  cfg_*   | in  | cfg_we           | register write, index cfg_index, data cfg_data
//
// One request at a time. A tick with no workers goes straight to the finish step. Otherwise
// the steps are: the average divide, the walk over the 64-entry history RAM (one
// read port, one entry a cycle), the decide step, then possibly the estimate divide
// or, after an upscale, the rescale pass over every entry; all divides share the one
// serial divider. Reset clears the history through per-entry valid bits, so no
// clearing pass is needed. A finished result waits in the output register while
// the next request is accepted; a stalled output holds the sequencer only at its
// last step.
module load_history_autoscaler_top
    import lhas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [16:0] total_load, [26:17] worker_count, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] action, [9:2] average_load,
                                   // [18:10] estimated_load, [25:19] over_count,
                                   // [32:26] under_count, rest zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers
    logic [9:0]  max_workers_reg, min_workers_reg;
    logic [6:0]  up_thresh_reg, down_thresh_reg, up_needed_reg, up_window_reg;
    logic [6:0]  down_window_reg;
    logic [15:0] down_delay_reg;

    // Sequencer state
    state_t              state_reg, state_next;
    logic [9:0]          n_reg, n_next;
    logic [HIST_AW-1:0]  wp_reg, wp_next;
    logic [15:0]         hold_reg, hold_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    pend_i_reg, pend_i_next;
    logic [6:0]          over_reg, over_next, under_reg, under_next;
    logic [13:0]         sum_reg, sum_next;
    logic [23:0]         prod_reg, prod_next;
    logic [16:0]         eden_reg, eden_next;
    action_t             act_reg, act_next;
    logic [7:0]          avg_reg, avg_next;
    logic [8:0]          est_reg, est_next;
    logic [HIST_DEPTH-1:0] valid_reg, valid_next;
    logic                valid_q_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [39:0]         out_data_reg, out_data_next;
    logic                out_load;

    // History RAM and divider
    logic                ram_we;
    logic [HIST_AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata, hist_h;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // Effective down-scaling settings: a zero minimum turns them all off
    logic [6:0]          d_th, d_win;
    logic [15:0]         d_delay, hold_base;
    logic [HIST_AW-1:0]  idx;
    logic                do_up;

    assign d_th    = (min_workers_reg != '0) ? down_thresh_reg : '0;
    assign d_win   = (min_workers_reg != '0) ? down_window_reg : '0;
    assign d_delay = (min_workers_reg != '0) ? down_delay_reg  : '0;
    assign idx     = wp_reg + 1'b1;
    assign hist_h  = valid_q_reg ? ram_rdata : '0;
    assign do_up   = (over_reg >= up_needed_reg) && (n_reg < max_workers_reg);
    assign hold_base = do_up ? d_delay : hold_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_workers_reg <= 10'd8;
            min_workers_reg <= 10'd1;
            up_thresh_reg   <= 7'd70;
            down_thresh_reg <= 7'd10;
            up_needed_reg   <= 7'd4;
            up_window_reg   <= 7'd5;
            down_window_reg <= 7'd10;
            down_delay_reg  <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_WORKERS: max_workers_reg <= cfg_data[9:0];
                CFG_MIN_WORKERS: min_workers_reg <= cfg_data[9:0];
                CFG_UP_THRESH:   up_thresh_reg   <= cfg_data[6:0];
                CFG_DOWN_THRESH: down_thresh_reg <= cfg_data[6:0];
                CFG_UP_NEEDED:   up_needed_reg   <= cfg_data[6:0];
                CFG_UP_WINDOW:   up_window_reg   <= cfg_data[6:0];
                CFG_DOWN_WINDOW: down_window_reg <= cfg_data[6:0];
                CFG_DOWN_DELAY:  down_delay_reg  <= cfg_data;
                default:         max_workers_reg <= max_workers_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    state_next = (s_tdata[26:17] == '0) ? ST_FINISH : ST_AVG_DIV;
                end
            ST_AVG_DIV:
                if (div_rsp.done)
                begin
                    state_next = ST_WALK;
                end
            ST_WALK:
                if (cnt_reg == CNT_W'(HIST_DEPTH) && !pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            ST_DECIDE:
                if (do_up)
                begin
                    state_next = ST_RS_READ;
                end
                else if (over_reg < up_needed_reg && d_win != '0 && under_reg == d_win
                         && n_reg > min_workers_reg && hold_reg == '0)
                begin
                    state_next = ST_EST_START;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            ST_EST_START: state_next = ST_EST_DIV;
            ST_EST_DIV:
                if (div_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            ST_RS_READ:  state_next = ST_RS_START;
            ST_RS_START: state_next = ST_RS_DIV;
            ST_RS_DIV:
                if (div_rsp.done)
                begin
                    state_next = (cnt_reg == CNT_W'(HIST_DEPTH - 1)) ? ST_FINISH
                                                                     : ST_RS_READ;
                end
            ST_FINISH:
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        n_next      = n_reg;
        wp_next     = wp_reg;
        hold_next   = hold_reg;
        cnt_next    = cnt_reg;
        pend_next   = 1'b0;
        pend_i_next = pend_i_reg;
        over_next   = over_reg;
        under_next  = under_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        eden_next   = eden_reg;
        act_next    = act_reg;
        avg_next    = avg_reg;
        est_next    = est_reg;
        valid_next  = valid_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx;
        ram_wdata   = avg_reg;
        ram_raddr   = wp_reg - cnt_reg[HIST_AW-1:0];
        div_req     = '0;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    n_next    = s_tdata[26:17];
                    act_next  = (s_tdata[26:17] == '0) ? ACT_NO_WORK : ACT_NONE;
                    avg_next  = '0;
                    est_next  = '0;
                    over_next = '0;
                    under_next = '0;
                    sum_next  = '0;
                    cnt_next  = '0;
                    div_req.start = (s_tdata[26:17] != '0);
                    div_req.num   = DIV_NUM_W'(s_tdata[16:0]);
                    div_req.den   = DIV_DEN_W'(s_tdata[26:17]);
                end
            ST_AVG_DIV:
                if (div_rsp.done)
                begin
                    // Store the clamped average in the next slot and advance the pointer
                    ram_we    = 1'b1;
                    ram_waddr = idx;
                    ram_wdata = (div_rsp.quo > 24'd255) ? 8'd255 : div_rsp.quo[7:0];
                    avg_next  = ram_wdata;
                    valid_next[idx] = 1'b1;
                    wp_next   = idx;
                end
            ST_WALK:
            begin
                if (cnt_reg != CNT_W'(HIST_DEPTH))
                begin
                    pend_next   = 1'b1;
                    pend_i_next = cnt_reg + 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if ({1'b0, hist_h} > {2'b0, up_thresh_reg} && pend_i_reg <= up_window_reg)
                    begin
                        over_next = over_reg + 1'b1;
                    end
                    else if ({1'b0, hist_h} < {2'b0, d_th} && pend_i_reg <= d_win)
                    begin
                        under_next = under_reg + 1'b1;
                    end
                    if (pend_i_reg <= d_win)
                    begin
                        sum_next = sum_reg + 14'(hist_h);
                    end
                end
            end
            ST_DECIDE:
            begin
                hold_next = (hold_base != '0) ? hold_base - 1'b1 : '0;
                prod_next = 24'(sum_reg) * 24'(n_reg);
                eden_next = 17'(d_win) * 17'(n_reg - 1'b1);
                cnt_next  = '0;
                if (do_up)
                begin
                    act_next = ACT_UP;
                end
            end
            ST_EST_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = prod_reg;
                div_req.den   = eden_reg;
            end
            ST_EST_DIV:
                if (div_rsp.done)
                begin
                    est_next = (div_rsp.quo > 24'd511) ? 9'd511 : div_rsp.quo[8:0];
                    if (div_rsp.quo < 24'(up_thresh_reg))
                    begin
                        act_next = ACT_DOWN;
                    end
                end
            ST_RS_READ:
                ram_raddr = cnt_reg[HIST_AW-1:0];
            ST_RS_START:
            begin
                // Rescale one entry by n/(n+1)
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(18'(hist_h) * 18'(n_reg));
                div_req.den   = DIV_DEN_W'({1'b0, n_reg} + 11'd1);
            end
            ST_RS_DIV:
                if (div_rsp.done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[HIST_AW-1:0];
                    ram_wdata = div_rsp.quo[7:0];
                    valid_next[cnt_reg[HIST_AW-1:0]] = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            ST_FINISH: ;
            default: ;
        endcase
    end

    // Output register: a waiting result holds until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, under_reg, over_reg, est_reg, avg_reg, act_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            hold_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            valid_q_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            hold_reg      <= hold_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            valid_q_reg   <= valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        pend_i_reg   <= pend_i_next;
        over_reg     <= over_next;
        under_reg    <= under_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        eden_reg     <= eden_next;
        act_reg      <= act_next;
        avg_reg      <= avg_next;
        est_reg      <= est_next;
        out_data_reg <= out_data_next;
    end

    lhas_ram #(
        .WIDTH(8),
        .DEPTH(HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lhas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_AVG_DIV || state_reg == ST_RS_DIV))
        else $error("history written outside its steps");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(HIST_DEPTH))
        else $error("history walk ran past the ring");

    a_up_has_over: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && act_reg == ACT_UP) |-> over_reg >= up_needed_reg)
        else $error("upscale without enough overloaded samples");

endmodule

/* tb/load_history_autoscaler_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the load history autoscaler top level.
module load_history_autoscaler_top_test;
    import lhas_pkg::*;

    // One expected decision as it leaves the block.
    typedef struct {
        action_t    act;
        logic [7:0] avg;
        logic [8:0] est;
        logic [6:0] over;
        logic [6:0] under;
    } decision_t;

    // Mirror of the decider: registers, history ring, hold-off, pending decisions.
    class decision_board;
        int unsigned regs [8];
        logic [7:0]  ring [HIST_DEPTH];
        int unsigned newest;
        int unsigned holdoff;
        decision_t   pending [$];
        int          errors;

        function void clear();
            regs = '{8, 1, 70, 10, 4, 5, 10, 0};
            foreach (ring[k]) ring[k] = '0;
            newest  = 0;
            holdoff = 0;
            errors  = 0;
        endfunction

        function void set_reg(cfg_index_t idx, int unsigned val);
            regs[idx] = val;
        endfunction

        // Work out the decision for one accepted tick and queue it.
        function void note_tick(int unsigned load, int unsigned n);
            decision_t   d;
            int unsigned d_th, d_win, d_delay, slot, k, i, a, h;
            longint unsigned sum, e;
            d = '{ACT_NONE, 0, 0, 0, 0};
            if (n == 0) begin
                d.act = ACT_NO_WORK;
                pending.push_back(d);
                return;
            end
            d_th    = regs[CFG_MIN_WORKERS] != 0 ? regs[CFG_DOWN_THRESH] : 0;
            d_win   = regs[CFG_MIN_WORKERS] != 0 ? regs[CFG_DOWN_WINDOW] : 0;
            d_delay = regs[CFG_MIN_WORKERS] != 0 ? regs[CFG_DOWN_DELAY] : 0;
            slot = (newest + 1) % HIST_DEPTH;
            a = load / n;
            if (a > 255) a = 255;
            ring[slot] = a[7:0];
            d.avg = a[7:0];
            k = slot;
            for (i = 1; i <= HIST_DEPTH; i++) begin
                h = ring[k];
                if (h > regs[CFG_UP_THRESH] && i <= regs[CFG_UP_WINDOW]) d.over++;
                else if (h < d_th && i <= d_win) d.under++;
                k = (k == 0) ? HIST_DEPTH - 1 : k - 1;
            end
            if (d.over >= regs[CFG_UP_NEEDED]) begin
                if (n < regs[CFG_MAX_WORKERS]) begin
                    d.act = ACT_UP;
                    // assume the new worker arrives: spread the history over n+1
                    foreach (ring[j]) ring[j] = (int'(ring[j]) * n) / (n + 1);
                    holdoff = d_delay;
                end
            end else if (d_win != 0 && d.under == d_win) begin
                if (n > regs[CFG_MIN_WORKERS] && holdoff == 0) begin
                    sum = 0;
                    k = slot;
                    for (i = 0; i < d_win && i < HIST_DEPTH; i++) begin
                        sum += ring[k];
                        k = (k == 0) ? HIST_DEPTH - 1 : k - 1;
                    end
                    e = (sum * n) / (longint'(d_win) * (n - 1));
                    d.est = e > 511 ? 9'd511 : e[8:0];
                    if (e < regs[CFG_UP_THRESH]) d.act = ACT_DOWN;
                end
            end
            newest = slot;
            if (holdoff != 0) holdoff--;
            pending.push_back(d);
        endfunction

        // Compare one delivered decision with the oldest pending one.
        function void check_result(logic [39:0] data);
            decision_t exp_d;
            bit        bad;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected decision %h", data);
                return;
            end
            exp_d = pending.pop_front();
            bad = data[1:0] != exp_d.act || data[9:2] != exp_d.avg ||
                  data[18:10] != exp_d.est || data[25:19] != exp_d.over ||
                  data[32:26] != exp_d.under;
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp act %0d avg %0d est %0d over %0d under %0d, %s",
                             exp_d.act, exp_d.avg, exp_d.est, exp_d.over, exp_d.under,
                             $sformatf("got act %0d avg %0d est %0d over %0d under %0d",
                                       data[1:0], data[9:2], data[18:10], data[25:19],
                                       data[32:26]));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    decision_board board;
    bit            no_idle;   // set for stretches with neither side idling
    bit            hi_run;    // current load regime of the well-formed stimulus

    load_history_autoscaler_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the decision output at random, about 16 times in a hundred, except while no_idle is set.
    always @(posedge clk)
    begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 16);
    end

    // Check each decision taken by the output handshake.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // Write one register while the block is idle; mirror it in the board.
    task automatic write_reg(cfg_index_t idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        board.set_reg(idx, val);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all(int unsigned v [8]);
        for (int i = 0; i < 8; i++) write_reg(cfg_index_t'(i), v[i]);
    endtask

    // Present one tick request, hold it until taken, then maybe idle a while.
    task automatic send_tick(int unsigned load, int unsigned n);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, n[9:0], load[16:0]};
        do @(posedge clk); while (!s_tready);
        board.note_tick(load, n);
        if (!no_idle && $urandom_range(99) < 16) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every pending decision has come back.
    task automatic drain();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Mostly well-formed runs of high or low load at plausible worker counts.
    task automatic random_tick();
        int unsigned n, a, load, top;
        if ($urandom_range(99) < 15) begin
            n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 999);
            send_tick($urandom_range(99900), n);
            return;
        end
        if ($urandom_range(7) == 0) hi_run = ($urandom_range(99) < 30);
        top = board.regs[CFG_MAX_WORKERS] + 2;
        if (top > 40) top = 40;
        n = $urandom_range(1, top);
        if (hi_run) a = $urandom_range(board.regs[CFG_UP_THRESH] + 1, 255);
        else a = $urandom_range(0, board.regs[CFG_DOWN_THRESH]);
        load = a * n + $urandom_range(n - 1);
        if (load > 99900) load = 99900;
        send_tick(load, n);
    endtask

    initial
    begin
        int unsigned v [8];
        board     = new();
        board.clear();
        no_idle   = 1'b0;
        hi_run    = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset settings, field extremes, no workers, an upscale, a downscale.
        send_tick(0, 0);
        send_tick(99900, 0);
        send_tick(0, 1);
        send_tick(99900, 1);
        send_tick(99900, 999);
        send_tick(0, 999);
        send_tick(1023, 4);
        repeat (4) send_tick(400, 4);
        repeat (11) send_tick(3, 4);
        drain();

        // Minimum of zero disables downscaling; zero up_needed scales up on every tick below the maximum.
        v = '{999, 0, 100, 99, 0, 64, 64, 65535};
        write_all(v);
        send_tick(5000, 2);
        send_tick(0, 998);
        send_tick(0, 999);
        drain();

        // Windows longer than the ring, a zero down threshold, hold-off across an upscale.
        v = '{1, 998, 1, 0, 64, 100, 100, 3};
        write_all(v);
        repeat (3) send_tick(99900, 999);
        drain();
        v = '{16, 1, 50, 99, 2, 3, 100, 3};
        write_all(v);
        repeat (2) send_tick(1000, 4);
        repeat (5) send_tick(10, 4);
        drain();

        // Random phases, each with its own register settings.
        for (int p = 0; p < 14; p++) begin
            v[CFG_MAX_WORKERS] = ($urandom_range(9) == 0) ? $urandom_range(1, 999)
                                                          : $urandom_range(2, 30);
            v[CFG_MIN_WORKERS] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
            v[CFG_UP_THRESH]   = $urandom_range(30, 100);
            v[CFG_DOWN_THRESH] = $urandom_range(0, 40);
            v[CFG_UP_NEEDED]   = $urandom_range(1, 8);
            v[CFG_UP_WINDOW]   = $urandom_range(1, 12);
            v[CFG_DOWN_WINDOW] = ($urandom_range(9) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 12);
            v[CFG_DOWN_DELAY]  = ($urandom_range(9) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 6);
            write_all(v);
            no_idle = (p == 5);
            for (int i = 0; i < 100; i++) begin
                random_tick();
                // once, hold the sender until every decision is back mid-phase
                if (p == 8 && i == 50) drain();
            end
            drain();
        end
        no_idle = 1'b0;

        drain();
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
